[rtl/core/tcs_pkg.sv]
// ----------------------------------------------------------------------------
// tcs_pkg
// Types, stream field offsets and opcodes for the four-register teaching CPU.
// ----------------------------------------------------------------------------
package tcs_pkg;

  localparam int DATA_W    = 32;
  localparam int MEM_WORDS = 32;
  localparam int MEM_AW    = 5;
  localparam int NUM_REGS  = 4;
  localparam int REG_AW    = 2;

  // slave tdata layout, lowest bit first
  localparam int IN_DATA_W   = 56;
  localparam int IN_ADDR_LSB = 0;
  localparam int IN_OP_LSB   = 5;
  localparam int IN_DEST_LSB = 9;
  localparam int IN_SRCA_LSB = 11;
  localparam int IN_SRCB_LSB = 13;
  localparam int IN_TGT_LSB  = 15;
  localparam int IN_VAL_LSB  = 20;

  // slave tuser bits
  localparam int TUSER_W     = 2;
  localparam int TUSER_FUNC  = 0;
  localparam int TUSER_INSTR = 1;

  // master tdata layout, lowest bit first
  localparam int OUT_DATA_W    = 80;
  localparam int OUT_PC_LSB    = 0;
  localparam int OUT_HALT_BIT  = 5;
  localparam int OUT_TAKEN_BIT = 6;
  localparam int OUT_RW_BIT    = 7;
  localparam int OUT_RI_LSB    = 8;
  localparam int OUT_WV_LSB    = 10;
  localparam int OUT_MW_BIT    = 42;
  localparam int OUT_MI_LSB    = 43;
  localparam int OUT_ALU_LSB   = 48;

  typedef enum logic [3:0] {
    OP_LOAD   = 4'd0,
    OP_STORE  = 4'd1,
    OP_MOVE   = 4'd2,
    OP_ADD    = 4'd3,
    OP_SUB    = 4'd4,
    OP_AND    = 4'd5,
    OP_OR     = 4'd6,
    OP_BRANCH = 4'd7,
    OP_BZERO  = 4'd8,
    OP_BNEG   = 4'd9,
    OP_HALT   = 4'd10,
    OP_NOP    = 4'd15
  } opcode_t;

  typedef struct packed {
    logic [3:0]        opcode;
    logic [REG_AW-1:0] dest;
    logic [REG_AW-1:0] src_a;
    logic [REG_AW-1:0] src_b;
    logic [MEM_AW-1:0] target;
  } instr_t;

  localparam int INSTR_W = $bits(instr_t);

  // payload holds either a data value or the instruction fields in its low bits
  typedef struct packed {
    logic              is_instr;
    logic [DATA_W-1:0] payload;
  } word_t;

  function automatic instr_t word_fields(word_t w);
    return instr_t'(w.payload[INSTR_W-1:0]);
  endfunction

  // data words and unused codes execute as NOP
  function automatic opcode_t decode_op(logic is_instr, logic [3:0] raw);
    opcode_t op;
    op = OP_NOP;
    if (is_instr) begin
      unique case (raw)
        OP_LOAD:   op = OP_LOAD;
        OP_STORE:  op = OP_STORE;
        OP_MOVE:   op = OP_MOVE;
        OP_ADD:    op = OP_ADD;
        OP_SUB:    op = OP_SUB;
        OP_AND:    op = OP_AND;
        OP_OR:     op = OP_OR;
        OP_BRANCH: op = OP_BRANCH;
        OP_BZERO:  op = OP_BZERO;
        OP_BNEG:   op = OP_BNEG;
        OP_HALT:   op = OP_HALT;
        default:   op = OP_NOP;
      endcase
    end
    return op;
  endfunction

endpackage

[rtl/core/teaching_cpu_step.sv]
// ----------------------------------------------------------------------------
// teaching_cpu_step
// Pipeline: decode, execute and output registers; one item per cycle while
// the output register is free or taken. Fetch and LOAD use the two read ports
// of the word memory, ALU operands the two read ports of the register memory.
// Reset: clears PC, ALU result, stage valids and the memory and register valid
// bits at once; the block takes items in the first cycle after reset.
// ----------------------------------------------------------------------------
module teaching_cpu_step
  import tcs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // mem_address, word_opcode, word_dest_reg, word_src_a, word_src_b,
  // word_target, word_value, zero pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // func, word_is_instruction
  input  logic [TUSER_W-1:0]    s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // program_counter, halted, branch_taken, reg_written, reg_index,
  // write_value, mem_written, mem_index, alu_result
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  logic adv;
  logic accept;

  // architectural state
  logic [MEM_AW-1:0] pc;
  logic [DATA_W-1:0] last_alu;

  // word memory
  word_t             mem [MEM_WORDS];
  logic [MEM_WORDS-1:0] mem_vld;
  logic              mem_wr_req;
  logic              mem_we;
  logic [MEM_AW-1:0] mem_waddr;
  word_t             mem_wdata;
  logic [MEM_AW-1:0] fetch_addr;
  logic [MEM_AW-1:0] load_addr;
  word_t             fetch_q, load_q;
  logic              fetch_vld, load_vld;
  logic              fetch_hit, load_hit;
  word_t             fetch_wd, load_wd;

  // register memory
  logic [DATA_W-1:0] rf [NUM_REGS];
  logic [NUM_REGS-1:0] rf_vld;
  logic              rf_wr_req;
  logic              rf_we;
  logic [REG_AW-1:0] rf_waddr;
  logic [DATA_W-1:0] rf_wdata;
  logic [REG_AW-1:0] ra_addr, rb_addr;
  logic [DATA_W-1:0] ra_q, rb_q, ra_wd, rb_wd;
  logic              ra_vld, rb_vld, ra_hit, rb_hit;

  // decode stage
  logic              s1_valid;
  logic              s1_func;
  logic [MEM_AW-1:0] s1_fetch_addr;
  logic [MEM_AW-1:0] s1_addr;
  word_t             s1_word;
  instr_t            in_instr;
  logic              in_is_instr;
  word_t             in_word;
  word_t             fetch_word;
  word_t             ir_word;
  instr_t            ir;
  opcode_t           d_op;
  logic [DATA_W-1:0] alu_cur;
  logic              d_taken;
  logic              d_halt;
  logic [MEM_AW-1:0] d_pc_next;

  // execute stage
  logic              s2_valid;
  logic              s2_host;
  opcode_t           s2_op;
  logic [REG_AW-1:0] s2_dest;
  logic [MEM_AW-1:0] s2_target;
  logic              s2_taken;
  logic              s2_halt;
  logic [MEM_AW-1:0] s2_pc;
  logic [MEM_AW-1:0] s2_addr;
  word_t             s2_word;
  logic [DATA_W-1:0] ra, rb;
  word_t             ld_word;
  logic [DATA_W-1:0] ld_val;
  logic              x_alu_we;
  logic [DATA_W-1:0] x_alu;
  logic              x_rw, x_mw;
  logic [DATA_W-1:0] x_wv;
  logic [DATA_W-1:0] x_alu_out;
  logic [REG_AW-1:0] x_ri;
  logic [MEM_AW-1:0] x_mi;

  // whole pipeline moves while the output register is free or being taken
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  assign accept        = s_axis_tvalid && adv;

  // ---------------------------------------------------------------- input
  assign in_is_instr = s_axis_tuser[TUSER_INSTR];
  assign in_instr = '{
    opcode: s_axis_tdata[IN_OP_LSB +: 4],
    dest:   s_axis_tdata[IN_DEST_LSB +: REG_AW],
    src_a:  s_axis_tdata[IN_SRCA_LSB +: REG_AW],
    src_b:  s_axis_tdata[IN_SRCB_LSB +: REG_AW],
    target: s_axis_tdata[IN_TGT_LSB +: MEM_AW]
  };
  assign in_word.is_instr = in_is_instr;
  assign in_word.payload  = in_is_instr ? {{(DATA_W-INSTR_W){1'b0}}, in_instr}
                                        : s_axis_tdata[IN_VAL_LSB +: DATA_W];

  // ---------------------------------------------------------------- word memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (adv) begin
      fetch_q <= mem[fetch_addr];
      load_q  <= mem[load_addr];
    end
  end

  // a write in the cycle of a read overrides the stale read data
  always_ff @(posedge clk) begin
    if (adv) begin
      fetch_vld <= mem_vld[fetch_addr];
      load_vld  <= mem_vld[load_addr];
      fetch_hit <= mem_we && (mem_waddr == fetch_addr);
      load_hit  <= mem_we && (mem_waddr == load_addr);
      fetch_wd  <= mem_wdata;
      load_wd   <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_vld <= '0;
    end else if (mem_we) begin
      mem_vld[mem_waddr] <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- register memory
  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf[rf_waddr] <= rf_wdata;
    end
    if (adv) begin
      ra_q   <= rf[ra_addr];
      rb_q   <= rf[rb_addr];
      ra_vld <= rf_vld[ra_addr];
      rb_vld <= rf_vld[rb_addr];
      ra_hit <= rf_we && (rf_waddr == ra_addr);
      rb_hit <= rf_we && (rf_waddr == rb_addr);
      ra_wd  <= rf_wdata;
      rb_wd  <= rf_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rf_vld <= '0;
    end else if (rf_we) begin
      rf_vld[rf_waddr] <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- stage 1
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_func       <= s_axis_tuser[TUSER_FUNC];
      s1_fetch_addr <= fetch_addr;
      s1_addr       <= s_axis_tdata[IN_ADDR_LSB +: MEM_AW];
      s1_word       <= in_word;
    end
  end

  assign fetch_word = fetch_hit ? fetch_wd : (fetch_vld ? fetch_q : word_t'('0));
  // the item in execute writes memory before this instruction runs
  assign ir_word = (mem_wr_req && (mem_waddr == s1_fetch_addr)) ? mem_wdata : fetch_word;
  assign ir      = word_fields(ir_word);
  assign d_op    = decode_op(ir_word.is_instr, ir.opcode);
  assign alu_cur = x_alu_we ? x_alu : last_alu;

  always_comb begin
    d_taken = 1'b0;
    d_halt  = 1'b0;
    if (s1_func) begin
      unique case (d_op)
        OP_BRANCH: d_taken = 1'b1;
        OP_BZERO:  d_taken = (alu_cur == '0);
        OP_BNEG:   d_taken = alu_cur[DATA_W-1];
        OP_HALT:   d_halt  = 1'b1;
        default:   d_taken = 1'b0;
      endcase
    end
  end

  always_comb begin
    priority if (!s1_func || d_halt) begin
      d_pc_next = pc;
    end else if (d_taken) begin
      d_pc_next = ir.target;
    end else begin
      d_pc_next = pc + MEM_AW'(1);
    end
  end

  assign fetch_addr = s1_valid ? d_pc_next : pc;
  assign load_addr  = ir.target;

  always_comb begin
    ra_addr = ir.src_a;
    if (d_op == OP_STORE) begin
      ra_addr = ir.dest;
    end else if (d_op == OP_LOAD) begin
      ra_addr = '0;
    end
  end
  assign rb_addr = ir.src_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
    end else if (adv && s1_valid) begin
      pc <= d_pc_next;
    end
  end

  // ---------------------------------------------------------------- stage 2
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid) begin
      s2_host   <= !s1_func;
      s2_op     <= s1_func ? d_op : OP_NOP;
      s2_dest   <= ir.dest;
      s2_target <= ir.target;
      s2_taken  <= d_taken;
      s2_halt   <= d_halt;
      s2_pc     <= d_pc_next;
      s2_addr   <= s1_addr;
      s2_word   <= s1_word;
    end
  end

  assign ra      = ra_hit ? ra_wd : (ra_vld ? ra_q : '0);
  assign rb      = rb_hit ? rb_wd : (rb_vld ? rb_q : '0);
  assign ld_word = load_hit ? load_wd : (load_vld ? load_q : word_t'('0));
  assign ld_val  = ld_word.is_instr ? '0 : ld_word.payload;

  always_comb begin
    x_alu_we = 1'b0;
    x_alu    = '0;
    x_rw     = 1'b0;
    x_mw     = 1'b0;
    x_wv     = '0;
    unique case (s2_op)
      OP_LOAD: begin
        x_alu_we = 1'b1;
        x_alu    = ra + ra;
        x_rw     = 1'b1;
        x_wv     = ld_val;
      end
      OP_STORE: begin
        x_alu_we = 1'b1;
        x_alu    = ra;
        x_mw     = 1'b1;
        x_wv     = ra;
      end
      OP_MOVE, OP_ADD, OP_SUB, OP_AND, OP_OR: begin
        x_alu_we = 1'b1;
        x_rw     = 1'b1;
        unique case (s2_op)
          OP_ADD:  x_alu = ra + rb;
          OP_SUB:  x_alu = ra - rb;
          OP_AND:  x_alu = ra & rb;
          OP_OR:   x_alu = ra | rb;
          default: x_alu = ra;
        endcase
        x_wv = x_alu;
      end
      default: begin
        x_alu_we = 1'b0;
      end
    endcase
    if (s2_host) begin
      x_wv = s2_word.is_instr ? '0 : s2_word.payload;
    end
    // gate with the stage valid so forwarding ignores an empty stage
    x_alu_we = x_alu_we && s2_valid;
  end

  assign mem_wr_req = s2_valid && (s2_host || x_mw);
  assign mem_we     = adv && mem_wr_req;
  assign mem_waddr  = s2_host ? s2_addr : s2_target;
  assign mem_wdata  = s2_host ? s2_word : word_t'{is_instr: 1'b0, payload: ra};

  assign rf_wr_req = s2_valid && x_rw;
  assign rf_we     = adv && rf_wr_req;
  assign rf_waddr  = s2_dest;
  assign rf_wdata  = x_wv;

  assign x_alu_out = x_alu_we ? x_alu : last_alu;
  assign x_ri      = x_rw ? s2_dest : '0;
  assign x_mi      = x_mw ? s2_target : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_alu <= '0;
    end else if (adv && x_alu_we) begin
      last_alu <= x_alu;
    end
  end

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      m_axis_tvalid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_valid) begin
      m_axis_tdata <= {x_alu_out, x_mi, x_mw, x_wv, x_ri, x_rw,
                       s2_taken, s2_halt, s2_pc};
    end
  end

endmodule

[rtl/core/tcs_checker.sv]
// ----------------------------------------------------------------------------
// tcs_checker
// Port-level checks on the result stream of the teaching CPU.
// ----------------------------------------------------------------------------
module tcs_checker
  import tcs_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  logic [MEM_AW-1:0] prev_pc;
  logic              halt_f, taken_f, rw_f, mw_f;

  assign halt_f  = m_axis_tdata[OUT_HALT_BIT];
  assign taken_f = m_axis_tdata[OUT_TAKEN_BIT];
  assign rw_f    = m_axis_tdata[OUT_RW_BIT];
  assign mw_f    = m_axis_tdata[OUT_MW_BIT];

  // track the PC each item starts from
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_pc <= '0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      prev_pc <= m_axis_tdata[OUT_PC_LSB +: MEM_AW];
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result item changed while stalled");

  a_one_effect: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> $onehot0({halt_f, taken_f, rw_f, mw_f}))
    else $error("more than one effect flagged on one item");

  a_idx_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (rw_f || m_axis_tdata[OUT_RI_LSB +: REG_AW] == '0) &&
                      (mw_f || m_axis_tdata[OUT_MI_LSB +: MEM_AW] == '0))
    else $error("index reported without a write");

  a_halt_pc: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && halt_f |-> m_axis_tdata[OUT_PC_LSB +: MEM_AW] == prev_pc)
    else $error("HALT moved the program counter");

endmodule

bind teaching_cpu_step tcs_checker u_tcs_checker (.*);
